// File: hdl/alm_pkg.sv
package alm_pkg;

	// Q0.16 luminance weights
	localparam logic [13:0] W_RED   = 14'd13926;
	localparam logic [15:0] W_GREEN = 16'd46884;
	localparam logic [12:0] W_BLUE  = 13'd4725;

	// reciprocal scaling: recip(a) = floor(2^RECIP_SHIFT / a)
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	// scaled product at or above 255*256 saturates the mask
	localparam logic [23:0] SAT_LIMIT = 24'd65280;
	localparam logic [7:0]  MASK_MAX  = 8'hFF;
	localparam logic [15:0] DIV_255   = 16'd255;

	typedef logic [RECIP_W-1:0] recip_t;
	typedef recip_t recip_lut_t [256];

	// premultiplied input pixel
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// unpremultiplied colors at full width, alpha kept alongside
	typedef struct packed {
		logic [7:0]  alpha;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} unpm_t;

	// restoring long division of 2^RECIP_SHIFT by each alpha, at elaboration
	function automatic recip_lut_t build_recip();
		recip_lut_t lut;
		logic [9:0] rem;
		logic [RECIP_W-1:0] quo;
		logic [9:0] dv;
		for (int a = 0; a < 256; a++) begin
			lut[a] = '0;
			if (a != 0) begin
				dv  = 10'(a);
				rem = '0;
				quo = '0;
				for (int k = RECIP_SHIFT; k >= 0; k--) begin
					rem = {rem[8:0], (k == RECIP_SHIFT)};
					if (rem >= dv) begin
						rem    = rem - dv;
						quo[k] = 1'b1;
					end
				end
				lut[a] = quo;
			end
		end
		return lut;
	endfunction

	localparam recip_lut_t RECIP_LUT = build_recip();

endpackage

// File: hdl/alm_pixel_if.sv
interface alm_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_alpha;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;

	modport source (
		output valid, pixel_alpha, pixel_red, pixel_green, pixel_blue,
		input  ready
	);
	modport sink (
		input  valid, pixel_alpha, pixel_red, pixel_green, pixel_blue,
		output ready
	);
endinterface

// File: hdl/alm_mask_if.sv
interface alm_mask_if;
	logic       valid;
	logic       ready;
	logic [7:0] mask_alpha;

	modport source (output valid, mask_alpha, input ready);
	modport sink (input valid, mask_alpha, output ready);
endinterface

// File: hdl/alm_unpremul.sv
// Three stages: c*255 and reciprocal lookup, reciprocal multiply,
// remainder check with a single +1 fix.
module alm_unpremul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  alm_pkg::pix_t  in_pix,
	output logic           out_valid,
	output alm_pkg::unpm_t out_pix
);

	logic [7:0]  chan_in [3];
	logic [15:0] n_in [3];

	logic                 valid_s1;
	logic [7:0]           alpha_s1;
	logic [15:0]          n_s1 [3];
	alm_pkg::recip_t      recip_s1;

	logic [40:0] prod_full [3];

	logic        valid_s2;
	logic [7:0]  alpha_s2;
	logic [15:0] n_s2 [3];
	logic [15:0] qhat_s2 [3];

	logic [15:0] qa [3];
	logic [15:0] rem [3];
	logic        fix [3];
	logic [15:0] q_fixed [3];

	logic        valid_s3;
	logic [7:0]  alpha_s3;
	logic [15:0] q_s3 [3];

	// stage 1 input: numerator c*255 = (c << 8) - c
	assign chan_in[0] = in_pix.red;
	assign chan_in[1] = in_pix.green;
	assign chan_in[2] = in_pix.blue;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_in[i] = {chan_in[i], 8'b0} - {8'b0, chan_in[i]};
		end
	end

	// stage 2 input: quotient estimate, at most one below the true value
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_full[i] = {25'b0, n_s1[i]} * {16'b0, recip_s1};
		end
	end

	// stage 3 input: remainder check; qhat*a never exceeds n
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qa[i]      = 16'(qhat_s2[i] * {8'b0, alpha_s2});
			rem[i]     = n_s2[i] - qa[i];
			fix[i]     = (rem[i] >= {8'b0, alpha_s2});
			q_fixed[i] = qhat_s2[i] + {15'b0, fix[i]};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s1 <= in_pix.alpha;
			recip_s1 <= alm_pkg::RECIP_LUT[in_pix.alpha];
			alpha_s2 <= alpha_s1;
			alpha_s3 <= alpha_s2;
			for (int i = 0; i < 3; i++) begin
				n_s1[i]    <= n_in[i];
				n_s2[i]    <= n_s1[i];
				qhat_s2[i] <= prod_full[i][39:24];
				q_s3[i]    <= q_fixed[i];
			end
		end
	end

	// zero alpha yields junk colors here; the alpha product clears them later
	assign out_valid     = valid_s3;
	assign out_pix.alpha = alpha_s3;
	assign out_pix.red   = q_s3[0];
	assign out_pix.green = q_s3[1];
	assign out_pix.blue  = q_s3[2];

`ifndef SYNTHESIS
	// estimate never overshoots the true quotient
	a_qhat_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ({8'b0, qhat_s2[0]} * {16'b0, alpha_s2}) <= {8'b0, n_s2[0]})
		else $error("red quotient estimate above true quotient");

	// one fix brings the remainder below alpha
	a_one_fix: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && alpha_s2 != '0 |->
			(rem[1] - (fix[1] ? {8'b0, alpha_s2} : 16'd0)) < {8'b0, alpha_s2})
		else $error("green quotient needs more than one correction");
`endif

endmodule

// File: hdl/alm_luma.sv
// Four stages: weight multiplies, luma sum, alpha multiply,
// divide by 2^16*255 with saturation into the output register.
module alm_luma (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  alm_pkg::unpm_t in_pix,
	output logic           out_valid,
	output logic [7:0]     mask_alpha
);

	logic        valid_s4;
	logic [7:0]  alpha_s4;
	logic [29:0] pr_s4;
	logic [31:0] pg_s4;
	logic [28:0] pb_s4;

	logic        valid_s5;
	logic [7:0]  alpha_s5;
	logic [31:0] luma_s5;

	logic        valid_s6;
	logic [7:0]  alpha_s6;
	logic [39:0] prod_s6;

	logic [23:0] x;
	logic        sat;
	logic [15:0] x16;
	logic [16:0] sum17;
	logic [7:0]  q0;
	logic [15:0] q0x255;
	logic [15:0] rem;
	logic        fix;
	logic [7:0]  mask_next;

	logic        valid_s7;
	logic [7:0]  mask_s7;

	// x = floor(prod / 2^16); result = floor(x / 255), saturated
	// estimate (x + x>>8) >> 8 is at most one low, then one fix
	assign x      = prod_s6[39:16];
	assign sat    = (x >= alm_pkg::SAT_LIMIT);
	assign x16    = x[15:0];
	assign sum17  = {1'b0, x16} + {9'b0, x16[15:8]};
	assign q0     = sum17[15:8];
	assign q0x255 = {q0, 8'b0} - {8'b0, q0};
	assign rem    = x16 - q0x255;
	assign fix    = (rem >= alm_pkg::DIV_255);
	assign mask_next = sat ? alm_pkg::MASK_MAX : (q0 + {7'b0, fix});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s4 <= in_pix.alpha;
			pr_s4    <= {16'b0, alm_pkg::W_RED} * {14'b0, in_pix.red};
			pg_s4    <= {16'b0, alm_pkg::W_GREEN} * {16'b0, in_pix.green};
			pb_s4    <= {16'b0, alm_pkg::W_BLUE} * {13'b0, in_pix.blue};
			alpha_s5 <= alpha_s4;
			luma_s5  <= {2'b0, pr_s4} + pg_s4 + {3'b0, pb_s4};
			alpha_s6 <= alpha_s5;
			prod_s6  <= {8'b0, luma_s5} * {32'b0, alpha_s5};
			mask_s7  <= mask_next;
		end
	end

	assign out_valid  = valid_s7;
	assign mask_alpha = mask_s7;

`ifndef SYNTHESIS
	// transparent pixel gives a zero mask
	a_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s6 && alpha_s6 == '0 |=> mask_s7 == '0)
		else $error("nonzero mask for zero alpha");

	// stalled result stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && !en |=> valid_s7 && $stable(mask_s7))
		else $error("output register changed during stall");
`endif

endmodule

// File: hdl/argb_luminance_mask_core.sv
// Luminance mask for premultiplied ARGB32 pixels. Each pixel beat gives one
// mask beat: colors are unpremultiplied as floor(c*255/alpha), weighted with
// Q0.16 luma weights (13926, 46884, 4725), multiplied by alpha and divided
// by 2^16*255, saturating at 255; zero alpha gives zero. The block takes one
// pixel per clock while the pipeline is not holding, through a seven-stage
// pipeline: three stages unpremultiply through a reciprocal table and
// multiply with a remainder fix, four compute luma, the alpha product and
// the final divide into the output register. The whole pipeline advances
// together; it holds when the output register is full and not taken, and
// pixel ready follows that condition combinationally.
module argb_luminance_mask_core (
	input  logic              clk,
	input  logic              arst_n,
	alm_pixel_if.sink         pixel,
	alm_mask_if.source        mask
);

	logic           en;
	alm_pkg::pix_t  in_pix;
	logic           unpm_valid;
	alm_pkg::unpm_t unpm_pix;
	logic           out_valid;
	logic [7:0]     out_mask;

	// pipeline advances unless a finished beat waits at the output
	assign en          = !out_valid || mask.ready;
	assign pixel.ready = en;

	assign in_pix.alpha = pixel.pixel_alpha;
	assign in_pix.red   = pixel.pixel_red;
	assign in_pix.green = pixel.pixel_green;
	assign in_pix.blue  = pixel.pixel_blue;

	alm_unpremul u_unpremul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pixel.valid),
		.in_pix    (in_pix),
		.out_valid (unpm_valid),
		.out_pix   (unpm_pix)
	);

	alm_luma u_luma (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (unpm_valid),
		.in_pix     (unpm_pix),
		.out_valid  (out_valid),
		.mask_alpha (out_mask)
	);

	assign mask.valid      = out_valid;
	assign mask.mask_alpha = out_mask;

endmodule

// File: bench/tb_argb_luminance_mask_core.sv
module tb_argb_luminance_mask_core;

	// Q0.16 luma weights and the final scale 2^16 * 255
	localparam longint unsigned LUMA_WR    = 13926;
	localparam longint unsigned LUMA_WG    = 46884;
	localparam longint unsigned LUMA_WB    = 4725;
	localparam longint unsigned LUMA_SCALE = 65536 * 255;
	localparam logic [7:0]      MASK_TOP   = 8'hFF;

	localparam int RANDOM_PIXELS = 1700;
	localparam int HOLD_CYCLES   = 120;
	localparam int HOLD_AFTER    = 300;
	localparam int DRAIN_CYCLES  = 24;
	localparam int CYCLE_LIMIT   = 400000;

	// directed pixel with an optional hand-computed mask
	typedef struct packed {
		alm_pkg::pix_t pix;
		logic          typed;
		logic [7:0]    mask;
	} probe_t;

	localparam int NUM_PROBES = 18;
	localparam probe_t PROBES [NUM_PROBES] = '{
		'{32'h00000000, 1'b1, 8'd0},   // all zero
		'{32'h00FFFFFF, 1'b1, 8'd0},   // zero alpha, bright colors: no divide
		'{32'hFFFFFFFF, 1'b1, 8'd254}, // full white opaque, weights sum short of 1.0
		'{32'hFF000000, 1'b1, 8'd0},   // opaque black
		'{32'hFFFF0000, 1'b0, 8'd0},   // pure red
		'{32'hFF00FF00, 1'b0, 8'd0},   // pure green
		'{32'hFF0000FF, 1'b0, 8'd0},   // pure blue
		'{32'h01FFFFFF, 1'b0, 8'd0},   // colors far above alpha
		'{32'h01010101, 1'b0, 8'd0},   // minimum alpha, well formed
		'{32'h010000FF, 1'b0, 8'd0},
		'{32'h80FF8000, 1'b0, 8'd0},   // red above alpha
		'{32'hFEFFFFFF, 1'b0, 8'd0},
		'{32'h80808080, 1'b0, 8'd0},
		'{32'h7F7F7F7F, 1'b0, 8'd0},
		'{32'hFFAA5533, 1'b0, 8'd0},
		'{32'h55AA55AA, 1'b0, 8'd0},
		'{32'h02FF0000, 1'b0, 8'd0},
		'{32'hC0102030, 1'b0, 8'd0}
	};

	logic clk;
	logic arst_n;

	alm_pixel_if pixel_bus ();
	alm_mask_if  mask_bus ();

	argb_luminance_mask_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_bus.sink),
		.mask   (mask_bus.source)
	);

	logic [7:0] pending_masks [$];
	int         mismatches;
	int         pixels_sent;
	int         cycle_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// single reset pulse at start of run
	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_argb_luminance_mask_core: errors");
			$finish;
		end
	end

	// luminance mask of one premultiplied pixel
	function automatic logic [7:0] luma_mask(alm_pkg::pix_t p);
		longint unsigned r, g, b, a, luma, m;
		a = 64'(p.alpha);
		if (a == 0) begin
			r = 64'(p.red);
			g = 64'(p.green);
			b = 64'(p.blue);
		end else begin
			r = (64'(p.red) * 255) / a;
			g = (64'(p.green) * 255) / a;
			b = (64'(p.blue) * 255) / a;
		end
		luma = LUMA_WR * r + LUMA_WG * g + LUMA_WB * b;
		m = (luma * a) / LUMA_SCALE;
		if (m > 64'(MASK_TOP))
			m = 64'(MASK_TOP);
		return m[7:0];
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// random pixel, mostly well formed with random content
	function automatic alm_pkg::pix_t random_pixel();
		alm_pkg::pix_t p;
		int            roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			p.alpha = 8'($urandom_range(1, 255));
			p.red   = 8'($urandom_range(0, p.alpha));
			p.green = 8'($urandom_range(0, p.alpha));
			p.blue  = 8'($urandom_range(0, p.alpha));
		end else if (roll < 80) begin
			case ($urandom_range(0, 3))
				0: p.alpha = 8'd0;
				1: p.alpha = 8'd1;
				2: p.alpha = 8'd254;
				default: p.alpha = 8'd255;
			endcase
			p.red   = 8'($urandom);
			p.green = 8'($urandom);
			p.blue  = 8'($urandom);
		end else if (roll < 90) begin
			// malformed: red and blue at or above alpha
			p.alpha = 8'($urandom_range(1, 254));
			p.red   = 8'($urandom_range(p.alpha, 255));
			p.green = 8'($urandom);
			p.blue  = 8'($urandom_range(p.alpha, 255));
		end else begin
			p = 32'($urandom);
		end
		return p;
	endfunction

	// offer one pixel, return at the edge where it is taken
	task automatic push_pixel(input alm_pkg::pix_t p, input logic typed,
			input logic [7:0] mask);
		logic taken;
		pixel_bus.valid       <= 1'b1;
		pixel_bus.pixel_alpha <= p.alpha;
		pixel_bus.pixel_red   <= p.red;
		pixel_bus.pixel_green <= p.green;
		pixel_bus.pixel_blue  <= p.blue;
		do begin
			@(negedge clk);
			taken = pixel_bus.ready;
			@(posedge clk);
		end while (!taken);
		pending_masks.push_back(typed ? mask : luma_mask(p));
		pixels_sent++;
	endtask

	task automatic idle_pixel(input int n);
		if (n > 0) begin
			pixel_bus.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// pixel source: directed table, then random blocks
	initial begin
		pixel_bus.valid       <= 1'b0;
		pixel_bus.pixel_alpha <= '0;
		pixel_bus.pixel_red   <= '0;
		pixel_bus.pixel_green <= '0;
		pixel_bus.pixel_blue  <= '0;
		pixels_sent = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int i = 0; i < NUM_PROBES; i++) begin
			push_pixel(PROBES[i].pix, PROBES[i].typed, PROBES[i].mask);
			idle_pixel(pick_gap());
		end

		// every fourth block of 50 runs back to back
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			push_pixel(random_pixel(), 1'b0, 8'd0);
			if ((i / 50) % 4 != 1)
				idle_pixel(pick_gap());
		end
		pixel_bus.valid <= 1'b0;

		while (pending_masks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_argb_luminance_mask_core: clean");
		else
			$display("tb_argb_luminance_mask_core: errors");
		$finish;
	end

	// mask sink: random stalls, calm stretches, one long hold-off
	initial begin
		bit held_off;
		int gap;
		held_off = 1'b0;
		mask_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && pixels_sent >= HOLD_AFTER) begin
				mask_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end else if ((cycle_count / 256) % 4 == 1) begin
				mask_bus.ready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					mask_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				mask_bus.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each mask beat with the oldest pending mask
	initial begin
		logic       beat;
		logic [7:0] got;
		logic [7:0] want;
		mismatches = 0;
		forever begin
			@(negedge clk);
			beat = mask_bus.valid === 1'b1 && mask_bus.ready === 1'b1;
			got  = mask_bus.mask_alpha;
			@(posedge clk);
			if (beat) begin
				if (pending_masks.size() == 0) begin
					$error("mask beat with no pixel pending: mask_alpha %0d", got);
					mismatches++;
				end else begin
					want = pending_masks.pop_front();
					if (got !== want) begin
						$error("mask_alpha: expected %0d, got %0d", want, got);
						mismatches++;
					end
				end
			end
		end
	end

endmodule
